/* rtl/core/ptt_pkg.sv */
package ptt_pkg;

    // APB register map: two 32-bit registers at byte addresses 0 and 4
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_PUBLIC_ADDR = 1'b0;
    localparam logic REG_BASE_PORT   = 1'b1;

    // Packet direction
    localparam logic CMD_OUTBOUND = 1'b0;
    localparam logic CMD_INBOUND  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_TRANSLATED = 2'd0;
    localparam logic [1:0] ST_NEW_MAP    = 2'd1;
    localparam logic [1:0] ST_IN_MISS    = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    typedef struct packed {
        logic        command;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port_in;
        logic [15:0] dst_port_in;
    } t_in_item;

    typedef struct packed {
        logic        forward;
        logic [31:0] out_src_addr;
        logic [15:0] out_src_port;
        logic [31:0] out_dst_addr;
        logic [15:0] out_dst_port;
        logic [1:0]  status;
    } t_out_item;

    // How the datapath builds the result transfer
    typedef enum logic [2:0] {
        RES_OUT_HIT = 3'd0,
        RES_NEW     = 3'd1,
        RES_FULL    = 3'd2,
        RES_IN_HIT  = 3'd3,
        RES_IN_MISS = 3'd4
    } t_res_kind;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      step;
        logic      finish;
        logic      alloc;
        t_res_kind kind;
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic inbound;
        logic empty;
        logic full;
        logic match;
        logic last;
        logic inb_hit;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/core/ptt_ram.sv */
module ptt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ptt_dp.sv */
module ptt_dp import ptt_pkg::*; #(
    parameter int TABLE_SIZE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_in_data,
    input  logic [31:0] i_public_addr,
    input  logic [15:0] i_base_port,
    input  t_ctl_cmd    i_cmd,
    output t_dp_sts     o_sts,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam int EW = 48;

    t_in_item          r_item;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     n_idx;
    logic [CW-1:0]     r_used;
    logic              r_inb_hit;
    logic              r_out_valid;
    t_out_item         r_out_data;
    t_out_item         n_out_data;
    logic [15:0]       in_diff;
    logic [EW-1:0]     rd_entry;
    logic              out_free;

    // Public port offset of an inbound packet
    assign in_diff = i_in_data.dst_port_in - i_base_port;

    // Pick next table index: inbound lookup, scan start at 0, scan advance, or hold
    always_comb begin
        if (i_cmd.load) begin
            n_idx = (i_in_data.command == CMD_INBOUND) ? in_diff[AW-1:0] : '0;
        end else if (i_cmd.step) begin
            n_idx = r_idx + AW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    ptt_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_SIZE)
    ) u_map_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.alloc),
        .i_waddr(r_used[AW-1:0]),
        .i_wdata({r_item.src_addr, r_item.src_port_in}),
        .i_raddr(n_idx),
        .o_rdata(rd_entry)
    );

    // Capture header and lookup index
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_item    <= i_in_data;
            r_inb_hit <= (in_diff < 16'(r_used));
        end
    end

    // Count allocated entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.alloc) begin
            r_used <= r_used + CW'(1);
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Status toward the controller
    always_comb begin
        o_sts.inbound  = i_in_data.command;
        o_sts.empty    = (r_used == '0);
        o_sts.full     = (r_used == CW'(TABLE_SIZE));
        o_sts.match    = (rd_entry == {r_item.src_addr, r_item.src_port_in});
        o_sts.last     = ((CW'(r_idx) + CW'(1)) == r_used);
        o_sts.inb_hit  = r_inb_hit;
        o_sts.out_free = out_free;
    end

    // Build the result transfer
    always_comb begin
        n_out_data.forward      = 1'b0;
        n_out_data.out_src_addr = r_item.src_addr;
        n_out_data.out_src_port = r_item.src_port_in;
        n_out_data.out_dst_addr = r_item.dst_addr;
        n_out_data.out_dst_port = r_item.dst_port_in;
        n_out_data.status       = ST_IN_MISS;
        case (i_cmd.kind)
            RES_OUT_HIT: begin
                n_out_data.forward      = 1'b1;
                n_out_data.out_src_addr = i_public_addr;
                n_out_data.out_src_port = i_base_port + 16'(r_idx);
                n_out_data.status       = ST_TRANSLATED;
            end
            RES_NEW: begin
                n_out_data.forward      = 1'b1;
                n_out_data.out_src_addr = i_public_addr;
                n_out_data.out_src_port = i_base_port + 16'(r_used);
                n_out_data.status       = ST_NEW_MAP;
            end
            RES_FULL: begin
                n_out_data.status = ST_FULL;
            end
            RES_IN_HIT: begin
                n_out_data.forward      = 1'b1;
                n_out_data.out_dst_addr = rd_entry[EW-1:16];
                n_out_data.out_dst_port = rd_entry[15:0];
                n_out_data.status       = ST_TRANSLATED;
            end
            default: begin
                n_out_data.status = ST_IN_MISS;
            end
        endcase
    end

    // Output register: hold while stalled, load on finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(TABLE_SIZE))
        else $error("entry count beyond table size");

    a_alloc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |-> !o_sts.full)
        else $error("allocation into a full table");

    a_used_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.alloc |=> $stable(r_used))
        else $error("entry count changed without allocation");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> out_free)
        else $error("result overwrites a pending transfer");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (CW'(r_idx) < r_used))
        else $error("scan index past allocated entries");
`endif

endmodule

/* rtl/core/ptt_ctl.sv */
module ptt_ctl import ptt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_sts  i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INB  = 4'b0010,
        S_SCAN = 4'b0100,
        S_MISS = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Sequence one packet: lookup or scan, then emit, allocating on an outbound miss with room
    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        o_cmd.alloc  = 1'b0;
        o_cmd.kind   = RES_IN_MISS;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.inbound) begin
                        n_state = S_INB;
                    end else if (i_sts.empty) begin
                        n_state = S_MISS;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_INB: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.kind   = i_sts.inb_hit ? RES_IN_HIT : RES_IN_MISS;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.match) begin
                    if (i_sts.out_free) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.kind   = RES_OUT_HIT;
                        n_state      = S_IDLE;
                    end
                end else if (i_sts.last) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_MISS: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                    if (i_sts.full) begin
                        o_cmd.kind = RES_FULL;
                    end else begin
                        o_cmd.kind  = RES_NEW;
                        o_cmd.alloc = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* rtl/core/port_address_translation_table.sv */
// Sequence: an inbound packet is looked up at its public port offset; an
//   outbound packet scans the allocated entries from entry 0 to a hit or the last.
// A new packet is taken only once the current one has its result registered;
//   the scan compares one table entry per cycle through the single RAM read port.
// Reset: entry count, state machine and output valid clear; the mapping RAM
//   is not cleared, only entries already allocated are read.
module port_address_translation_table import ptt_pkg::*; #(
    parameter int TABLE_SIZE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [31:0] r_public_addr;
    logic [15:0] r_base_port;
    logic        cfg_wr;
    t_ctl_cmd    cmd;
    t_dp_sts     sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_public_addr <= '0;
            r_base_port   <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PUBLIC_ADDR: r_public_addr <= pwdata;
                REG_BASE_PORT:   r_base_port   <= pwdata[15:0];
                default:         r_base_port   <= r_base_port;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (paddr[2])
            REG_PUBLIC_ADDR: prdata = r_public_addr;
            REG_BASE_PORT:   prdata = {16'd0, r_base_port};
            default:         prdata = '0;
        endcase
    end

    ptt_ctl u_ctl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    ptt_dp #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (i_in_data),
        .i_public_addr(r_public_addr),
        .i_base_port  (r_base_port),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule
